// ===== hw/rtl/pdpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdpb_pkg: shared types and constants of the proximity dedup point buffer
// command codes, result status codes, register indexes and field widths
// ----------------------------------------------------------------------------
package pdpb_pkg;
   localparam int unsigned CoordWidth = 24;
   localparam int unsigned TagWidth   = 32;
   localparam int unsigned DistWidth  = 52;
   localparam int unsigned CmdWidth   = 2;
   localparam int unsigned StatWidth  = 3;
   localparam int unsigned CountWidth = 6;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic [TagWidth-1:0]          tag_type;
   typedef logic [DistWidth-1:0]         dist_type;

   // command codes
   localparam logic [CmdWidth-1:0] CMD_INSERT  = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_PURGE   = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_READOUT = 2'd2;

   // status codes
   localparam logic [StatWidth-1:0] ST_INSERTED = 3'd0;
   localparam logic [StatWidth-1:0] ST_FULL     = 3'd1;
   localparam logic [StatWidth-1:0] ST_NEAR     = 3'd2;
   localparam logic [StatWidth-1:0] ST_PURGED   = 3'd3;
   localparam logic [StatWidth-1:0] ST_ENTRY    = 3'd4;

   // register indexes
   localparam logic CSR_MIN_SEP   = 1'b0;
   localparam logic CSR_MAX_RANGE = 1'b1;
endpackage

// ===== hw/rtl/proximity_dedup_point_buffer.sv =====
`timescale 1ns / 1ps
// insert compares the point with the stored entries and stops at the first near one; purge compares every
// entry and moves each kept one; readout gives every entry in turn; full-table insert and empty readout scan nothing
// the single squared-difference multiplier, used three times per entry, sets the pace
// one command at a time: a new command is taken only when idle and no result is pending
// reset: synchronous active high, clears the fill count and control, registers to defaults
// ----------------------------------------------------------------------------
// proximity_dedup_point_buffer
// ordered point table with nearness-rejecting insert, range purge and readout
// ----------------------------------------------------------------------------
module proximity_dedup_point_buffer
   import pdpb_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   // cmd[1:0], pos_x[25:2], pos_y[49:26], pos_z[73:50], tag_in[105:74], pad
   input  logic [111:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // status[2:0], out_x[26:3], out_y[50:27], out_z[74:51], tag_out[106:75],
   // count[112:107], pad
   output logic [119:0] rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [51:0]  csr_wdata
);
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

   localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_MUL = 4'd2, S_ACC = 4'd3,
      S_DEC = 4'd4, S_OUT = 4'd5, S_RO_RD = 4'd6, S_RO_OUT = 4'd7, S_MV = 4'd8;

   // memories
   coord_type mx [TABLE_DEPTH];
   coord_type my [TABLE_DEPTH];
   coord_type mz [TABLE_DEPTH];
   tag_type   mt [TABLE_DEPTH];

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in, idx_ff, idx_in, wp_ff, wp_in;
   logic [1:0]          ax_ff, ax_in;
   logic [CmdWidth-1:0] cmd_ff, cmd_in;
   coord_type           px_ff, py_ff, pz_ff, rx_ff, ry_ff, rz_ff;
   tag_type             ptag_ff, rt_ff;
   dist_type            min_ff, max_ff;
   logic [49:0]         acc_ff, acc_in;
   logic [47:0]         sq_ff;
   logic                near_ff, near_in;
   logic [119:0]        out_ff, out_in;
   logic                ov_ff, ov_in, ol_ff, ol_in;
   logic                rd_en, wr_en;
   logic [AW-1:0]       wr_addr;
   coord_type           wx, wy, wz;
   tag_type             wt;
   logic signed [24:0]  diff;
   logic [24:0]         mag;

   assign req_tready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = ol_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '1;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_MIN_SEP) min_ff <= csr_wdata;
         else max_ff <= csr_wdata;
      end
   end

   // table memory, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mx[wr_addr] <= wx;
         my[wr_addr] <= wy;
         mz[wr_addr] <= wz;
         mt[wr_addr] <= wt;
      end
      if (rd_en) begin
         rx_ff <= mx[idx_ff[AW-1:0]];
         ry_ff <= my[idx_ff[AW-1:0]];
         rz_ff <= mz[idx_ff[AW-1:0]];
         rt_ff <= mt[idx_ff[AW-1:0]];
      end
   end

   // shared squared-difference unit, one axis per use
   always_comb begin
      case (ax_ff)
         2'd0:    diff = {rx_ff[23], rx_ff} - {px_ff[23], px_ff};
         2'd1:    diff = {ry_ff[23], ry_ff} - {py_ff[23], py_ff};
         default: diff = {rz_ff[23], rz_ff} - {pz_ff[23], pz_ff};
      endcase
      mag = diff[24] ? 25'(-diff) : diff;
   end

   always_ff @(posedge clock) begin
      sq_ff <= 48'(mag[23:0] * mag[23:0]);
      if (state_ff == S_IDLE && req_tvalid && req_tready) begin
         px_ff   <= req_tdata[25:2];
         py_ff   <= req_tdata[49:26];
         pz_ff   <= req_tdata[73:50];
         ptag_ff <= req_tdata[105:74];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      wp_in    = wp_ff;
      ax_in    = ax_ff;
      cmd_in   = cmd_ff;
      acc_in   = acc_ff;
      near_in  = near_ff;
      out_in   = out_ff;
      ov_in    = ov_ff;
      ol_in    = ol_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = wp_ff[AW-1:0];
      wx = rx_ff; wy = ry_ff; wz = rz_ff; wt = rt_ff;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in  = req_tdata[1:0];
               idx_in  = '0;
               wp_in   = '0;
               near_in = 1'b0;
               case (req_tdata[1:0])
                  CMD_INSERT:  state_in = (fill_ff >= DepthC) ? S_OUT : S_RD;
                  CMD_PURGE:   state_in = S_RD;
                  CMD_READOUT: state_in = S_RO_RD;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_RD: begin
            if (idx_ff >= fill_ff || near_ff) begin
               state_in = S_OUT;
            end else begin
               rd_en    = 1'b1;
               ax_in    = 2'd0;
               acc_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + 50'(sq_ff);
            if (ax_ff == 2'd2) begin
               state_in = S_DEC;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_DEC: begin
            idx_in = idx_ff + 1'b1;
            if (cmd_ff == CMD_INSERT) begin
               if (52'(acc_ff) < min_ff) near_in = 1'b1;
               state_in = S_RD;
            end else begin
               state_in = (52'(acc_ff) > max_ff) ? S_RD : S_MV;
            end
         end
         S_MV: begin
            wr_en    = 1'b1;
            wp_in    = wp_ff + 1'b1;
            state_in = S_RD;
         end
         S_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in    = 1'b1;
               ol_in    = 1'b1;
               state_in = S_IDLE;
               out_in   = '0;
               if (cmd_ff == CMD_PURGE) begin
                  fill_in = wp_ff;
                  out_in[2:0] = ST_PURGED;
                  out_in[112:107] = 6'(wp_ff);
               end else if (fill_ff >= DepthC) begin
                  out_in[2:0] = ST_FULL;
                  out_in[112:107] = 6'(fill_ff);
               end else if (near_ff) begin
                  out_in[2:0] = ST_NEAR;
                  out_in[112:107] = 6'(fill_ff);
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = fill_ff[AW-1:0];
                  wx = px_ff; wy = py_ff; wz = pz_ff; wt = ptag_ff;
                  fill_in = fill_ff + 1'b1;
                  out_in[2:0] = ST_INSERTED;
                  out_in[112:107] = 6'(fill_ff + 1'b1);
               end
            end
         end
         S_RO_RD: begin
            if (fill_ff == '0) begin
               if (!ov_ff || rsp_tready) begin
                  ov_in = 1'b1;
                  ol_in = 1'b1;
                  out_in = '0;
                  out_in[2:0] = ST_ENTRY;
                  state_in = S_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_RO_OUT;
            end
         end
         S_RO_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in  = 1'b1;
               ol_in  = (idx_ff + 1'b1 == fill_ff);
               out_in = {7'd0, 6'(fill_ff), rt_ff, rz_ff, ry_ff, rx_ff, ST_ENTRY};
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff + 1'b1 == fill_ff) ? S_IDLE : S_RO_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         ov_ff    <= 1'b0;
         ol_ff    <= 1'b0;
         idx_ff   <= '0;
         wp_ff    <= '0;
         ax_ff    <= '0;
         cmd_ff   <= CMD_INSERT;
         near_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ov_ff    <= ov_in;
         ol_ff    <= ol_in;
         idx_ff   <= idx_in;
         wp_ff    <= wp_in;
         ax_ff    <= ax_in;
         cmd_ff   <= cmd_in;
         near_ff  <= near_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      out_ff <= out_in;
   end
endmodule
